// ===== hdl/ngga_pkg.sv =====
// Shared types, character codes and text tables for the GGA display formatter.
`timescale 1ns / 1ps

package ngga_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_NL    = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Command kinds queued between parser and expander
  typedef enum logic [2:0] {
    OP_ITEMS = 3'd0,  // explicit list of up to three results
    OP_TIME  = 3'd1,  // "Time: " label
    OP_LAT   = 3'd2,  // "Lat:  " label
    OP_LON   = 3'd3,  // "Lon: " label
    OP_ALT   = 3'd4,  // "Alt:  " label
    OP_SEC   = 3'd5   // seconds digits from minute fraction
  } op_t;

  localparam int ItemMax   = 3;
  localparam int FracW     = 17;
  localparam int QueueDepth = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    op_t                     op;
    logic [1:0]              n;      // item count for OP_ITEMS
    item_t [ItemMax-1:0]     items;
    logic [FracW-1:0]        frac;   // for OP_SEC
  } cmd_t;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Text, first character in the top byte
  localparam logic [47:0] TXT_HDR  = "$GPGGA";
  localparam logic [47:0] TXT_TIME = "Time: ";
  localparam logic [47:0] TXT_LAT  = "Lat:  ";
  localparam logic [47:0] TXT_LON  = "Lon:  ";
  localparam logic [47:0] TXT_ALT  = "Alt:  ";

  // Seconds = frac * 60 / 100000, as (frac * SecMul) >> SecShift, exact for frac < 100000
  localparam int SecShift = 30;
  localparam logic [19:0] SecMul = 20'd644246;

  function automatic logic [7:0] text_char(input logic [47:0] txt, input logic [2:0] idx);
    logic [5:0] base;
    base = 6'd47 - {idx, 3'b000};
    return txt[base -: 8];
  endfunction

  function automatic logic [7:0] label_char(input op_t op, input logic [2:0] idx);
    logic [7:0] c;
    unique case (op)
      OP_TIME: c = text_char(TXT_TIME, idx);
      OP_LAT:  c = text_char(TXT_LAT, idx);
      OP_LON:  c = text_char(TXT_LON, idx);
      OP_ALT:  c = text_char(TXT_ALT, idx);
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic item_t mk_item(input kind_t kind, input logic [7:0] ch);
    item_t it;
    it.kind = kind;
    it.ch   = ch;
    return it;
  endfunction

endpackage

// ===== hdl/ngga_front.sv =====
// Sentence parser: follows the GGA field layout and issues at most one display command per byte.
`timescale 1ns / 1ps

module ngga_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output ngga_pkg::cmd_t  push_cmd
);

  typedef enum logic [14:0] {
    PH_HDR   = 15'b000000000000001,
    PH_IDLE  = 15'b000000000000010,
    PH_PRE   = 15'b000000000000100,
    PH_TIME  = 15'b000000000001000,
    PH_SEPA  = 15'b000000000010000,
    PH_DEG   = 15'b000000000100000,
    PH_MIN   = 15'b000000001000000,
    PH_DOT   = 15'b000000010000000,
    PH_FRAC  = 15'b000000100000000,
    PH_SKIPC = 15'b000001000000000,
    PH_HEMI  = 15'b000010000000000,
    PH_SEPB  = 15'b000100000000000,
    PH_SKIP3 = 15'b001000000000000,
    PH_ALT   = 15'b010000000000000,
    PH_UNIT  = 15'b100000000000000
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [ngga_pkg::FracW-1:0] frac_r, frac_nxt;
  logic                       lonf_r, lonf_nxt;

  logic                       acc;
  logic [7:0]                 c;
  logic [4:0]                 cnt_inc;
  logic                       is_digit;
  logic [20:0]                frac_mac;
  logic [7:0]                 deg_ch;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign c        = in_byte;
  assign cnt_inc  = {1'b0, cnt_r} + 5'd1;
  assign is_digit = (c >= ngga_pkg::CH_ZERO) && (c <= ngga_pkg::CH_NINE);
  assign frac_mac = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0}
                  + {13'd0, c - ngga_pkg::CH_ZERO};
  // leading zero of the longitude degrees shows as a blank
  assign deg_ch   = (lonf_r && cnt_r == 4'd0 && c == ngga_pkg::CH_ZERO) ?
                    ngga_pkg::CH_SPACE : c;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    frac_nxt  = frac_r;
    lonf_nxt  = lonf_r;
    push      = 1'b0;
    push_cmd  = '0;
    push_cmd.op = ngga_pkg::OP_ITEMS;

    if (c == ngga_pkg::CH_LF) begin
      phase_nxt = PH_HDR;
      cnt_nxt   = 4'd0;
      frac_nxt  = '0;
      lonf_nxt  = 1'b0;
    end else if (c == ngga_pkg::CH_NUL) begin
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_HDR: begin
          if (cnt_r < 4'd6 && c == ngga_pkg::text_char(ngga_pkg::TXT_HDR, cnt_r[2:0])) begin
            if (cnt_r == 4'd5) begin
              push = 1'b1;
              push_cmd.n = 2'd1;
              push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CLEAR, ngga_pkg::CH_NUL);
              phase_nxt = PH_PRE;
              cnt_nxt   = 4'd0;
            end else begin
              cnt_nxt = cnt_inc[3:0];
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_PRE: begin
          if (c == ngga_pkg::CH_COMMA) begin
            push = 1'b1;
            push_cmd.op = ngga_pkg::OP_TIME;
            phase_nxt = PH_TIME;
            cnt_nxt   = 4'd0;
          end
        end
        PH_TIME: begin
          push = 1'b1;
          push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, c);
          if (cnt_r == 4'd1 || cnt_r == 4'd3) begin
            push_cmd.n = 2'd2;
            push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_COLON);
          end else if (cnt_r >= 4'd8) begin
            push_cmd.n = 2'd3;
            push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_SPACE);
            push_cmd.items[2] = ngga_pkg::mk_item(ngga_pkg::KIND_NL, ngga_pkg::CH_NUL);
          end else begin
            push_cmd.n = 2'd1;
          end
          if (cnt_r >= 4'd8) begin
            phase_nxt = PH_SEPA;
            cnt_nxt   = 4'd0;
          end else begin
            cnt_nxt = cnt_inc[3:0];
          end
        end
        PH_SEPA: begin
          if (c == ngga_pkg::CH_COMMA) begin
            push = 1'b1;
            push_cmd.op = ngga_pkg::OP_LAT;
            lonf_nxt  = 1'b0;
            phase_nxt = PH_DEG;
            cnt_nxt   = 4'd0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DEG: begin
          push = 1'b1;
          push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, deg_ch);
          if (cnt_inc >= (lonf_r ? 5'd3 : 5'd2)) begin
            push_cmd.n = 2'd2;
            push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_SPACE);
            phase_nxt = PH_MIN;
            cnt_nxt   = 4'd0;
          end else begin
            push_cmd.n = 2'd1;
            cnt_nxt = cnt_inc[3:0];
          end
        end
        PH_MIN: begin
          push = 1'b1;
          push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, c);
          if (cnt_r >= 4'd1) begin
            push_cmd.n = 2'd2;
            push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_SPACE);
            phase_nxt = PH_DOT;
            cnt_nxt   = 4'd0;
          end else begin
            push_cmd.n = 2'd1;
            cnt_nxt = cnt_inc[3:0];
          end
        end
        PH_DOT: begin
          phase_nxt = PH_FRAC;
          cnt_nxt   = 4'd0;
          frac_nxt  = '0;
        end
        PH_FRAC: begin
          if (!is_digit) begin
            phase_nxt = PH_IDLE;
          end else begin
            frac_nxt = frac_mac[ngga_pkg::FracW-1:0];
            if (cnt_r >= 4'd4) begin
              push = 1'b1;
              push_cmd.op   = ngga_pkg::OP_SEC;
              push_cmd.frac = frac_mac[ngga_pkg::FracW-1:0];
              phase_nxt = PH_SKIPC;
              cnt_nxt   = 4'd0;
            end else begin
              cnt_nxt = cnt_inc[3:0];
            end
          end
        end
        PH_SKIPC: phase_nxt = PH_HEMI;
        PH_HEMI: begin
          push = 1'b1;
          push_cmd.n = 2'd3;
          push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_SPACE);
          push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, c);
          push_cmd.items[2] = ngga_pkg::mk_item(ngga_pkg::KIND_NL, ngga_pkg::CH_NUL);
          phase_nxt = PH_SEPB;
        end
        PH_SEPB: begin
          if (c != ngga_pkg::CH_COMMA) begin
            phase_nxt = PH_IDLE;
          end else if (!lonf_r) begin
            push = 1'b1;
            push_cmd.op = ngga_pkg::OP_LON;
            lonf_nxt  = 1'b1;
            phase_nxt = PH_DEG;
            cnt_nxt   = 4'd0;
          end else begin
            phase_nxt = PH_SKIP3;
            cnt_nxt   = 4'd0;
          end
        end
        PH_SKIP3: begin
          if (c == ngga_pkg::CH_COMMA) begin
            if (cnt_inc >= 5'd3) begin
              push = 1'b1;
              push_cmd.op = ngga_pkg::OP_ALT;
              phase_nxt = PH_ALT;
              cnt_nxt   = 4'd0;
            end else begin
              cnt_nxt = cnt_inc[3:0];
            end
          end
        end
        PH_ALT: begin
          if (c == ngga_pkg::CH_COMMA) begin
            phase_nxt = PH_UNIT;
          end else begin
            push = 1'b1;
            push_cmd.n = 2'd1;
            push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, c);
          end
        end
        PH_UNIT: begin
          push = 1'b1;
          push_cmd.n = 2'd2;
          push_cmd.items[0] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, ngga_pkg::CH_SPACE);
          push_cmd.items[1] = ngga_pkg::mk_item(ngga_pkg::KIND_CHAR, c);
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (!acc) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      cnt_r   <= 4'd0;
      frac_r  <= '0;
      lonf_r  <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      frac_r  <= frac_nxt;
      lonf_r  <= lonf_nxt;
    end
  end

endmodule

// ===== hdl/ngga_cmd_fifo.sv =====
// Four-entry command queue between parser and expander.
`timescale 1ns / 1ps

module ngga_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ngga_pkg::cmd_t  push_cmd,
  output logic            full,
  output logic            head_valid,
  output ngga_pkg::cmd_t  head_cmd,
  input  logic            pop
);

  localparam int PtrW = $clog2(ngga_pkg::QueueDepth);

  ngga_pkg::cmd_t entry_r [ngga_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PtrW:0]   count_r, count_nxt;

  assign full       = (count_r == (PtrW + 1)'(ngga_pkg::QueueDepth));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/ngga_back.sv =====
// Command expander: queued commands to the output register, one result per cycle unless stalled.
`timescale 1ns / 1ps

module ngga_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  ngga_pkg::cmd_t  head_cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  logic [2:0]  idx_r, idx_nxt;
  logic        ov_r;
  logic [7:0]  ch_r;
  logic [1:0]  kind_r;
  logic        last_r;

  logic [36:0] sec_prod;
  logic [5:0]  sec;
  logic [3:0]  tens;
  logic [5:0]  units;
  logic [2:0]  len;
  logic [7:0]  res_ch;
  ngga_pkg::kind_t res_kind;
  logic        res_last;
  logic        load;
  logic        emit;
  ngga_pkg::item_t cur_item;

  // seconds from the five-digit fraction, below 60
  assign sec_prod = 37'(head_cmd.frac) * 37'(ngga_pkg::SecMul);
  assign sec      = sec_prod[ngga_pkg::SecShift +: 6];

  always_comb begin
    priority if (sec >= 6'd50) tens = 4'd5;
    else if (sec >= 6'd40)     tens = 4'd4;
    else if (sec >= 6'd30)     tens = 4'd3;
    else if (sec >= 6'd20)     tens = 4'd2;
    else if (sec >= 6'd10)     tens = 4'd1;
    else                       tens = 4'd0;
  end

  assign units = sec - ({2'b00, tens} * 6'd10);

  always_comb begin
    unique case (head_cmd.op)
      ngga_pkg::OP_ITEMS: len = {1'b0, head_cmd.n};
      ngga_pkg::OP_LON:   len = 3'd5;
      ngga_pkg::OP_SEC:   len = (tens != 4'd0) ? 3'd2 : 3'd1;
      default:            len = 3'd6;
    endcase
  end

  assign cur_item = head_cmd.items[idx_r[1:0]];

  always_comb begin
    res_kind = ngga_pkg::KIND_CHAR;
    res_ch   = ngga_pkg::CH_NUL;
    unique case (head_cmd.op)
      ngga_pkg::OP_ITEMS: begin
        res_kind = cur_item.kind;
        res_ch   = cur_item.ch;
      end
      ngga_pkg::OP_SEC: begin
        if (len == 3'd2 && idx_r == 3'd0) begin
          res_ch = ngga_pkg::CH_ZERO + {4'd0, tens};
        end else begin
          res_ch = ngga_pkg::CH_ZERO + {2'd0, units};
        end
      end
      default: res_ch = ngga_pkg::label_char(head_cmd.op, idx_r);
    endcase
  end

  assign res_last = (idx_r + 3'd1 == len);
  assign load     = !ov_r || out_ready;
  assign emit     = head_valid && load;
  assign pop      = emit && res_last;
  assign idx_nxt  = pop ? 3'd0 : idx_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      ov_r  <= 1'b0;
    end else begin
      if (emit) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        ov_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ch_r   <= res_ch;
      kind_r <= res_kind;
      last_r <= res_last;
    end
  end

  assign out_valid = ov_r;
  assign out_char  = ch_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

// ===== hdl/nmea_gga_display_formatter_top.sv =====
// Top level of the GGA sentence to display stream formatter.
`timescale 1ns / 1ps

// Channel  Dir  Ports                       Request
// in       in   in_tvalid/tready/tdata      one received byte, tdata[7:0] = rx_byte
// out      out  out_tvalid/tready/tdata     one display result: char, kind (tuser), last
//                    /tuser/tlast
//
// A byte is taken in any cycle in which the four-entry command queue has room.
// The parser handles it in that cycle and queues at most one command; the
// expander sends one result per cycle while out_tready allows, so a byte
// yields as many results as its command holds (zero to six), labels longest.
// Reset (rst_n low, synchronous) returns the parser to header search and empties
// the queue and the output register. Output stalls back up through the queue to
// in_tready only once all four entries are in use.

module nmea_gga_display_formatter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast
);

  logic           q_full;
  logic           push;
  ngga_pkg::cmd_t push_cmd;
  logic           head_valid;
  ngga_pkg::cmd_t head_cmd;
  logic           pop;

  // front: header match, field tracking, fraction accumulation
  ngga_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples the byte side from output back-pressure
  ngga_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // back: label text, seconds conversion, one result a cycle while the output accepts
  ngga_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
